// ----- rtl/tfe_pkg.sv -----
// Shared constants, codes and the X.25 CRC step for the telemetry frame encoder.
// Used by telemetry_frame_encoder and its checker; depends on nothing else.
package tfe_pkg;

  // Frame constants.
  localparam logic [7:0]  START_BYTE = 8'hFE;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;

  // Input word kinds carried on s_tuser.
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_PAYLOAD = 1'b1;

  // Register select bit values (paddr[2]).
  localparam logic REG_SYSTEM_ID    = 1'b0;
  localparam logic REG_COMPONENT_ID = 1'b1;

  // Output buffer depth: a zero-length frame produces the most words.
  localparam int unsigned BURST_DEPTH = 8;
  localparam int unsigned COUNT_W     = $clog2(BURST_DEPTH + 1);

  // One byte of the reflected X.25 CRC-16.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

// ----- rtl/telemetry_frame_encoder.sv -----
// The first word of an item's output is offered in the cycle after the item is accepted.
// Throughput: while m_tready is high, a payload item that does not end its frame is taken every
// cycle; otherwise the input waits until the eight-word output buffer has drained, one word per
// ready cycle (6 words for a start item, 8 for a zero-length frame, 3 for a closing byte).
// Reset (rst, synchronous, active high) clears the sequence count, CRC, frame state and the
// output buffer, and sets system_id and component_id to 1.
//
// MAVLink v1 frame encoder: header, payload pass-through and CRC trailer.
// Depends on tfe_pkg.
module telemetry_frame_encoder (
  input  logic        clk,
  input  logic        rst,
  // Input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [7:0] message_id, [15:8] payload_length,
                                 // [23:16] crc_seed, [31:24] payload_byte
  input  logic        s_tuser,   // [0] req_type
  // Output words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] frame_byte
  output logic        m_tlast,   // frame_end
  output logic        m_tuser,   // [0] stray_byte
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tfe_pkg::*;

  // Configuration registers.
  logic [7:0] system_id;
  logic [7:0] component_id;

  // Frame state.
  logic [7:0]  sequence_count, sequence_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  saved_extra, saved_extra_next;
  logic        frame_open, frame_open_next;

  // Output buffer: slot 0 is on the master port, the rest shift down.
  logic [7:0]         burst_byte [BURST_DEPTH];
  logic               burst_last [BURST_DEPTH];
  logic               burst_stray[BURST_DEPTH];
  logic [COUNT_W-1:0] burst_count;

  logic [7:0]         load_byte [BURST_DEPTH];
  logic               load_last [BURST_DEPTH];
  logic               load_stray[BURST_DEPTH];
  logic [COUNT_W-1:0] load_count;

  logic        in_take, out_take;
  logic [7:0]  f_msg, f_len, f_extra, f_data;
  logic [15:0] crc_a, crc_b, crc_c, crc_d, crc_e, crc_x, crc_p;
  logic [7:0]  left_dec;

  assign f_msg   = s_tdata[7:0];
  assign f_len   = s_tdata[15:8];
  assign f_extra = s_tdata[23:16];
  assign f_data  = s_tdata[31:24];

  // Handshakes: take a new item once the buffer will be empty after this cycle.
  assign m_tvalid = (burst_count != '0);
  assign out_take = m_tvalid && m_tready;
  assign s_tready = (burst_count == '0) ||
                    ((burst_count == COUNT_W'(1)) && m_tready);
  assign in_take  = s_tvalid && s_tready;

  assign m_tdata = burst_byte[0];
  assign m_tlast = burst_last[0];
  assign m_tuser = burst_stray[0];

  // CRC chains for the header and for one payload byte.
  assign crc_a = crc_step(CRC_INIT, f_len);
  assign crc_b = crc_step(crc_a, sequence_count);
  assign crc_c = crc_step(crc_b, system_id);
  assign crc_d = crc_step(crc_c, component_id);
  assign crc_e = crc_step(crc_d, f_msg);
  assign crc_p = crc_step(running_crc, f_data);
  assign left_dec = bytes_left - 8'd1;

  // Trailer CRC: after the header for an empty frame, else after the payload byte.
  assign crc_x = (s_tuser == REQ_START) ? crc_step(crc_e, f_extra)
                                        : crc_step(crc_p, saved_extra);

  // Words and next state for the item at the input.
  always_comb begin
    for (int i = 0; i < BURST_DEPTH; i++) begin
      load_byte[i]  = 8'h00;
      load_last[i]  = 1'b0;
      load_stray[i] = 1'b0;
    end
    load_count          = '0;
    sequence_count_next = sequence_count;
    running_crc_next    = running_crc;
    bytes_left_next     = bytes_left;
    saved_extra_next    = saved_extra;
    frame_open_next     = frame_open;

    if (s_tuser == REQ_START) begin
      load_byte[0] = START_BYTE;
      load_byte[1] = f_len;
      load_byte[2] = sequence_count;
      load_byte[3] = system_id;
      load_byte[4] = component_id;
      load_byte[5] = f_msg;
      sequence_count_next = sequence_count + 8'd1;
      saved_extra_next    = f_extra;
      if (f_len == 8'd0) begin
        load_byte[6]     = crc_x[7:0];
        load_byte[7]     = crc_x[15:8];
        load_last[7]     = 1'b1;
        load_count       = COUNT_W'(8);
        running_crc_next = CRC_INIT;
        bytes_left_next  = 8'd0;
        frame_open_next  = 1'b0;
      end else begin
        load_count       = COUNT_W'(6);
        running_crc_next = crc_e;
        bytes_left_next  = f_len;
        frame_open_next  = 1'b1;
      end
    end else if (!frame_open) begin
      // Payload with no open frame: flag it and drop the byte.
      load_stray[0] = 1'b1;
      load_count    = COUNT_W'(1);
    end else begin
      load_byte[0] = f_data;
      if (left_dec == 8'd0) begin
        load_byte[1]     = crc_x[7:0];
        load_byte[2]     = crc_x[15:8];
        load_last[2]     = 1'b1;
        load_count       = COUNT_W'(3);
        running_crc_next = CRC_INIT;
        bytes_left_next  = 8'd0;
        frame_open_next  = 1'b0;
      end else begin
        load_count       = COUNT_W'(1);
        running_crc_next = crc_p;
        bytes_left_next  = left_dec;
      end
    end
  end

  // Frame state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_count <= 8'd0;
      running_crc    <= CRC_INIT;
      bytes_left     <= 8'd0;
      saved_extra    <= 8'd0;
      frame_open     <= 1'b0;
      system_id      <= 8'd1;
      component_id   <= 8'd1;
    end else begin
      if (in_take) begin
        sequence_count <= sequence_count_next;
        running_crc    <= running_crc_next;
        bytes_left     <= bytes_left_next;
        saved_extra    <= saved_extra_next;
        frame_open     <= frame_open_next;
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_SYSTEM_ID) begin
          system_id <= pwdata[7:0];
        end else begin
          component_id <= pwdata[7:0];
        end
      end
    end
  end

  // Output buffer fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_count <= '0;
    end else if (in_take) begin
      burst_count <= load_count;
    end else if (out_take) begin
      burst_count <= burst_count - COUNT_W'(1);
    end
  end

  // Output buffer contents: load a whole item, or shift one word out.
  always_ff @(posedge clk) begin
    if (in_take) begin
      for (int i = 0; i < BURST_DEPTH; i++) begin
        burst_byte[i]  <= load_byte[i];
        burst_last[i]  <= load_last[i];
        burst_stray[i] <= load_stray[i];
      end
    end else if (out_take) begin
      for (int i = 0; i < BURST_DEPTH - 1; i++) begin
        burst_byte[i]  <= burst_byte[i+1];
        burst_last[i]  <= burst_last[i+1];
        burst_stray[i] <= burst_stray[i+1];
      end
    end
  end

  // Register reads; low address bits are ignored.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_COMPONENT_ID) ? {24'h000000, component_id}
                                                 : {24'h000000, system_id};

endmodule

// ----- rtl/tfe_checker.sv -----
// Port-level checks for telemetry_frame_encoder, attached by the bind below.
// Depends on tfe_pkg.
module tfe_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);
  import tfe_pkg::*;

  // A stalled output word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word withdrawn while stalled");

  // A start item opens its output with the start byte on the next cycle.
  a_start_byte: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == REQ_START) |=> m_tvalid && (m_tdata == START_BYTE))
    else $error("frame does not begin with the start byte");

  // Every accepted item produces at least one word right away.
  a_item_output: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted item produced no word");

  // A stray flag word is a zero byte and never closes a frame.
  a_stray_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tlast && (m_tdata == 8'h00))
    else $error("malformed stray flag word");

  // Input is held off while an output word is stalled.
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output buffer is stalled");

endmodule

bind telemetry_frame_encoder tfe_checker u_tfe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
